### rtl/core/vpa_pkg.sv
// vpa_pkg: shared types, constants and helper functions of the voice pool allocator
// used by vpa_ctrl, vpa_dp and voice_pool_allocator_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package vpa_pkg;

    // pool geometry
    localparam int NUM_VOICES      = 48;
    localparam int VOICES_PER_CORE = 24;
    localparam int OWNER_BITS      = 16;

    // field widths
    localparam int OP_W      = 2;
    localparam int OWNER_W   = 16;
    localparam int VOICE_W   = 6;
    localparam int SLOT_W    = 5;
    localparam int STATUS_W  = 2;
    localparam int VOICE_SPACE = 1 << VOICE_W;

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_MONO    = 2'd0,
        OP_STEREO  = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOFREE   = 2'd1,
        ST_NOTUSED  = 2'd2,
        ST_MISMATCH = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIRST,
        S_SECOND
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the input transfer
        logic first;    // first search / owner read cycle
        logic commit;   // update state and load the result register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_stall;   // result register full and not being taken
    } dp_status_t;

    // lowest clear bit of one half: {found, position}
    function automatic logic [SLOT_W:0] lowest_free(input logic [VOICES_PER_CORE-1:0] busy);
        logic              found;
        logic [SLOT_W-1:0] pos;
        found = 1'b0;
        pos   = '0;
        for (int i = VOICES_PER_CORE - 1; i >= 0; i--) begin
            if (!busy[i]) begin
                found = 1'b1;
                pos   = SLOT_W'(i);
            end
        end
        return {found, pos};
    endfunction

    // position within a half to voice number
    function automatic logic [VOICE_W-1:0] to_voice(input logic [SLOT_W-1:0] pos,
                                                    input logic reverb);
        return VOICE_W'(pos) + (reverb ? VOICE_W'(0) : VOICE_W'(VOICES_PER_CORE));
    endfunction

    // voice number to {core, slot}, one compare and subtract
    function automatic logic [SLOT_W:0] voice_split(input logic [VOICE_W-1:0] v);
        logic core;
        logic [VOICE_W-1:0] rem;
        core = (v >= VOICE_W'(VOICES_PER_CORE));
        rem  = core ? (v - VOICE_W'(VOICES_PER_CORE)) : v;
        return {core, rem[SLOT_W-1:0]};
    endfunction

endpackage
`default_nettype wire

### rtl/core/vpa_ctrl.sv
// vpa_ctrl: sequencing state machine of the voice pool allocator
// depends on vpa_pkg (state_t, ctrl_cmd_t, dp_status_t)
`timescale 1ns / 1ps
`default_nettype none
module vpa_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire vpa_pkg::dp_status_t st,
    output vpa_pkg::ctrl_cmd_t       cmd
);
    import vpa_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_FIRST;
                end
            end
            S_FIRST: begin
                cmd.first  = 1'b1;
                state_next = S_SECOND;
            end
            S_SECOND: begin
                // finish once the result register can take the result
                if (!st.out_stall) begin
                    cmd.commit = 1'b1;
                    s_tready   = 1'b1;
                    if (s_tvalid) begin
                        cmd.load   = 1'b1;
                        state_next = S_FIRST;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/vpa_dp.sv
// vpa_dp: datapath of the voice pool allocator: busy bits, owner memory,
// priority searches and result register; depends on vpa_pkg
`timescale 1ns / 1ps
`default_nettype none
module vpa_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire vpa_pkg::ctrl_cmd_t                cmd,
    output vpa_pkg::dp_status_t                    st,
    input  wire logic [vpa_pkg::S_TDATA_W-1:0]     s_tdata,  // owner_id, voice_index
    input  wire logic [vpa_pkg::S_TUSER_W-1:0]     s_tuser,  // op, use_reverb_pool
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic [vpa_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic [vpa_pkg::M_TUSER_W-1:0]          m_tuser
);
    import vpa_pkg::*;

    // captured request
    logic [OP_W-1:0]       op_reg;
    logic                  reverb_reg;
    logic [OWNER_BITS-1:0] owner_reg;
    logic [VOICE_W-1:0]    idx_reg;

    // allocation state
    logic [NUM_VOICES-1:0] busy_reg, busy_next;
    logic [OWNER_BITS-1:0] owner_mem [NUM_VOICES];
    logic [OWNER_BITS-1:0] rdata_reg;

    // first search result
    logic                  found1_reg;
    logic [SLOT_W-1:0]     pos1_reg;

    // result register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0]  m_tuser_reg, m_tuser_next;

    logic [VOICES_PER_CORE-1:0] half_busy, half_busy2;
    logic [SLOT_W:0]            search1, search2;
    logic [VOICE_W-1:0]         voice1, voice2, voice1_now;
    logic [SLOT_W:0]            split1, split2;
    logic [VOICE_SPACE-1:0]     busy_pad;
    logic                       idx_in_range, rel_busy, is_claim, stereo_ok;
    status_t                    status;
    logic                       put1, put2;

    // capture the input transfer
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= s_tuser[OP_W-1:0];
            reverb_reg <= s_tuser[OP_W];
            owner_reg  <= s_tdata[OWNER_BITS-1:0];
            idx_reg    <= s_tdata[OWNER_W +: VOICE_W];
        end
    end

    // searches over the chosen half
    always_comb begin
        half_busy  = reverb_reg ? busy_reg[VOICES_PER_CORE-1:0]
                                : busy_reg[NUM_VOICES-1:VOICES_PER_CORE];
        search1    = lowest_free(half_busy);
        voice1_now = to_voice(search1[SLOT_W-1:0], reverb_reg);
        half_busy2 = half_busy | (VOICES_PER_CORE'(1) << pos1_reg);
        search2    = lowest_free(half_busy2);
        voice1     = to_voice(pos1_reg, reverb_reg);
        voice2     = to_voice(search2[SLOT_W-1:0], reverb_reg);
        split1     = voice_split(voice1);
        split2     = voice_split(voice2);
    end

    assign is_claim     = (op_reg == OP_MONO) || (op_reg == OP_STEREO);
    assign stereo_ok    = (op_reg == OP_STEREO) && found1_reg && search2[SLOT_W];
    assign idx_in_range = (idx_reg < VOICE_W'(NUM_VOICES));
    assign busy_pad     = VOICE_SPACE'(busy_reg);
    assign rel_busy     = idx_in_range && busy_pad[idx_reg];

    // first search is held for the finishing cycle
    always_ff @(posedge aclk) begin
        if (cmd.first) begin
            found1_reg <= search1[SLOT_W];
            pos1_reg   <= search1[SLOT_W-1:0];
        end
    end

    // owner memory: tag the first voice early, the second at commit
    always_ff @(posedge aclk) begin
        if (cmd.first && is_claim && search1[SLOT_W]) begin
            owner_mem[voice1_now] <= owner_reg;
        end else if (cmd.commit && stereo_ok) begin
            owner_mem[voice2] <= owner_reg;
        end
        if (idx_in_range) begin
            rdata_reg <= owner_mem[idx_reg];
        end
    end

    // outcome of the request
    always_comb begin
        status    = ST_OK;
        put1      = 1'b0;
        put2      = 1'b0;
        busy_next = busy_reg;
        case (op_reg)
            OP_MONO: begin
                if (!found1_reg) begin
                    status = ST_NOFREE;
                end else begin
                    put1              = 1'b1;
                    busy_next[voice1] = 1'b1;
                end
            end
            OP_STEREO: begin
                if (!stereo_ok) begin
                    status = ST_NOFREE;
                end else begin
                    put1              = 1'b1;
                    put2              = 1'b1;
                    busy_next[voice1] = 1'b1;
                    busy_next[voice2] = 1'b1;
                end
            end
            OP_RELEASE: begin
                if (!rel_busy) begin
                    status = ST_NOTUSED;
                end else if (rdata_reg != owner_reg) begin
                    status = ST_MISMATCH;
                end else begin
                    busy_next[idx_reg] = 1'b0;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
        m_tuser_next = M_TUSER_W'(status);
        m_tdata_next = {put2 ? split2[SLOT_W-1:0] : SLOT_W'(0),
                        put2 ? split2[SLOT_W] : 1'b0,
                        put2 ? voice2 : VOICE_W'(0),
                        put1 ? split1[SLOT_W-1:0] : SLOT_W'(0),
                        put1 ? split1[SLOT_W] : 1'b0,
                        put1 ? voice1 : VOICE_W'(0)};
    end

    // busy bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= '0;
        end else if (cmd.commit) begin
            busy_reg <= busy_next;
        end
    end

    // result register
    assign m_tvalid_next = cmd.commit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign st.out_stall = m_tvalid_reg && !m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign m_tuser      = m_tuser_reg;

endmodule
`default_nettype wire

### rtl/core/voice_pool_allocator_unit.sv
// voice_pool_allocator_unit: top level, a request goes through capture, then the first
// search or owner read, then the second search and commit; a new transfer is
// accepted in the commit cycle, so a new request is taken only as the last one commits;
// a result still waiting in the result register holds
// the commit and the input; reset (aresetn low, synchronous): all voices free, no result pending
// depends on vpa_pkg, vpa_ctrl, vpa_dp
`timescale 1ns / 1ps
`default_nettype none
module voice_pool_allocator_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [vpa_pkg::S_TDATA_W-1:0] s_tdata,  // owner_id[15:0], voice_index[21:16]
    input  wire logic [vpa_pkg::S_TUSER_W-1:0] s_tuser,  // op[1:0], use_reverb_pool[2]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // first_voice[5:0], first_core[6], first_slot[11:7],
    // second_voice[17:12], second_core[18], second_slot[23:19]
    output logic [vpa_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [vpa_pkg::M_TUSER_W-1:0]      m_tuser   // status[1:0]
);
    import vpa_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;

    // sequencing
    vpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // allocation state and result
    vpa_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .st       (st),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef NO_ASSERTIONS
    // a result is never committed over one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(m_tvalid && !m_tready))
        else $error("result committed while output stalled");

    // every input transfer is followed by its search cycle
    a_accept_then_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (cmd.first && !s_tready))
        else $error("search cycle missing after input transfer");

    // a stereo pair is reported lowest voice first
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_OK && m_tdata[17:12] != 6'd0)
            |-> (m_tdata[17:12] > m_tdata[5:0]))
        else $error("stereo pair out of order");
`endif

endmodule
`default_nettype wire
